// ----- rtl/pdf_pkg.sv -----
// Shared types and constants for the protobuf data field parser.
// Used by pdf_varint, pdf_parser and protobuf_data_field_parser; no dependencies.
package pdf_pkg;

	localparam int BYTE_W    = 8;
	localparam int ACC_W     = 35;
	localparam int PORT_W    = 32;
	localparam int LEN_OUT_W = 9;
	localparam int NB_W      = 4;

	localparam logic [6:0]      VARINT_BITS_MASK = 7'h7F;
	localparam int              CONT_BIT         = 7;
	localparam logic [2:0]      WT_MASK          = 3'h7;
	localparam logic [NB_W-1:0] VARINT_SLOTS     = 4'd5;  // bytes that still land in the accumulator
	localparam logic [NB_W-1:0] VARINT_LAST_IDX  = 4'd9;  // tenth byte must end the varint

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_I64    = 3'd1;
	localparam logic [2:0] WT_LEN    = 3'd2;
	localparam logic [2:0] WT_I32    = 3'd5;

	localparam logic [PORT_W-1:0] FIELD_PORT    = 32'd1;
	localparam logic [PORT_W-1:0] FIELD_PAYLOAD = 32'd2;

	localparam int SKIP_I64 = 8;
	localparam int SKIP_I32 = 4;

	typedef enum logic [2:0] {
		PH_KEY      = 3'd0,
		PH_PORT     = 3'd1,
		PH_PLEN     = 3'd2,
		PH_PAYLOAD  = 3'd3,
		PH_SKIPVAR  = 3'd4,
		PH_SKIPLEN  = 3'd5,
		PH_SKIPBYTE = 3'd6,
		PH_HALT     = 3'd7
	} pdf_phase_t;

	typedef struct packed {
		logic             done;
		logic             fail;
		logic [ACC_W-1:0] accum;
		logic [NB_W-1:0]  nbytes;
	} pdf_varint_t;

	typedef struct packed {
		logic                 payload_valid;
		logic [BYTE_W-1:0]    payload_value;
		logic                 payload_clear;
		logic                 message_done;
		logic                 message_ok;
		logic [PORT_W-1:0]    port_number;
		logic [LEN_OUT_W-1:0] payload_length;
	} pdf_result_t;

endpackage

// ----- rtl/pdf_varint.sv -----
// One step of varint decoding: folds a byte into the 35-bit accumulator.
// Depends on pdf_pkg.
module pdf_varint import pdf_pkg::*; (
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [ACC_W-1:0]  accum,
	input  logic [NB_W-1:0]   nbytes,
	input  logic              sat,
	output pdf_varint_t       vi
);

	logic [6:0]       bits;
	logic [ACC_W-1:0] shifted;

	assign bits = data_byte[6:0] & VARINT_BITS_MASK;

	always_comb begin
		case (nbytes[2:0])
			3'd0:    shifted = {28'd0, bits};
			3'd1:    shifted = {21'd0, bits, 7'd0};
			3'd2:    shifted = {14'd0, bits, 14'd0};
			3'd3:    shifted = {7'd0, bits, 21'd0};
			default: shifted = {bits, 28'd0};
		endcase
	end

	always_comb begin
		vi.accum = accum;
		if (nbytes < VARINT_SLOTS) begin
			vi.accum = accum | shifted;
		end else if (bits != 7'd0 && sat) begin
			vi.accum = '1;  // length too wide: saturate
		end
		vi.done   = !data_byte[CONT_BIT];
		vi.fail   = data_byte[CONT_BIT] && (nbytes >= VARINT_LAST_IDX);
		vi.nbytes = (vi.done || vi.fail) ? '0 : nbytes + 4'd1;
	end

endmodule

// ----- rtl/pdf_parser.sv -----
// Parse state and per-byte decode: key, port, payload length, payload and skip phases.
// Depends on pdf_pkg and pdf_varint.
module pdf_parser import pdf_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              last_byte,
	output pdf_result_t       res
);

	localparam int LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);

	pdf_phase_t        phase_q, phase_nx, phase_d;
	logic [ACC_W-1:0]  accum_q, accum_d;
	logic [NB_W-1:0]   nbytes_q, nbytes_d;
	logic [LEN_W-1:0]  skip_q, skip_d;
	logic [PORT_W-1:0] port_q, port_d;
	logic [LEN_W-1:0]  len_q, len_d;

	pdf_varint_t       vi;
	logic              sat;
	logic [PORT_W-1:0] fnum;
	logic [2:0]        wt;
	logic [LEN_W-1:0]  n_sat;
	logic              ok;

	assign sat = (phase_q == PH_PLEN) || (phase_q == PH_SKIPLEN);

	pdf_varint u_varint (
		.data_byte (data_byte),
		.accum     (accum_q),
		.nbytes    (nbytes_q),
		.sat       (sat),
		.vi        (vi)
	);

	assign fnum  = vi.accum[ACC_W-1:3];
	assign wt    = vi.accum[2:0] & WT_MASK;
	assign n_sat = (vi.accum > ACC_W'(MAX_MESSAGE_BYTES)) ?
		LEN_W'(MAX_MESSAGE_BYTES) : LEN_W'(vi.accum);

	// next phase, before the end-of-message reset
	always_comb begin
		phase_nx = phase_q;
		case (phase_q)
			PH_KEY: begin
				if (vi.fail) begin
					phase_nx = PH_HALT;
				end else if (vi.done) begin
					if (fnum == FIELD_PORT && wt == WT_VARINT) begin
						phase_nx = PH_PORT;
					end else if (fnum == FIELD_PAYLOAD && wt == WT_LEN) begin
						phase_nx = PH_PLEN;
					end else begin
						case (wt)
							WT_VARINT: phase_nx = PH_SKIPVAR;
							WT_I64:    phase_nx = PH_SKIPBYTE;
							WT_LEN:    phase_nx = PH_SKIPLEN;
							WT_I32:    phase_nx = PH_SKIPBYTE;
							default:   phase_nx = PH_HALT;
						endcase
					end
				end
			end
			PH_PORT, PH_SKIPVAR: begin
				if (vi.fail) begin
					phase_nx = PH_HALT;
				end else if (vi.done) begin
					phase_nx = PH_KEY;
				end
			end
			PH_PLEN: begin
				if (vi.fail) begin
					phase_nx = PH_HALT;
				end else if (vi.done) begin
					phase_nx = (n_sat == '0) ? PH_KEY : PH_PAYLOAD;
				end
			end
			PH_SKIPLEN: begin
				if (vi.fail) begin
					phase_nx = PH_HALT;
				end else if (vi.done) begin
					phase_nx = (n_sat == '0) ? PH_KEY : PH_SKIPBYTE;
				end
			end
			PH_PAYLOAD, PH_SKIPBYTE: begin
				if (skip_q == LEN_W'(1)) begin
					phase_nx = PH_KEY;
				end
			end
			default: phase_nx = phase_q;
		endcase
	end

	// HALT is the only error phase, so a clean end is "back at a key boundary"
	assign ok      = (phase_nx == PH_KEY) && (nbytes_d == '0);
	assign phase_d = last_byte ? PH_KEY : phase_nx;

	// datapath and result
	always_comb begin
		accum_d  = accum_q;
		nbytes_d = nbytes_q;
		skip_d   = skip_q;
		port_d   = port_q;
		len_d    = len_q;
		res      = '0;
		case (phase_q)
			PH_KEY, PH_PORT, PH_PLEN, PH_SKIPVAR, PH_SKIPLEN: begin
				accum_d  = (vi.done || vi.fail) ? '0 : vi.accum;
				nbytes_d = vi.nbytes;
				if (vi.fail) begin
					skip_d = '0;
				end else if (vi.done) begin
					case (phase_q)
						PH_KEY: begin
							if (!(fnum == FIELD_PORT && wt == WT_VARINT) &&
							    !(fnum == FIELD_PAYLOAD && wt == WT_LEN)) begin
								if (wt == WT_I64) begin
									skip_d = LEN_W'(SKIP_I64);
								end else if (wt == WT_I32) begin
									skip_d = LEN_W'(SKIP_I32);
								end
							end
						end
						PH_PORT: port_d = vi.accum[PORT_W-1:0];
						PH_PLEN: begin
							len_d             = n_sat;
							skip_d            = n_sat;
							res.payload_clear = 1'b1;
						end
						PH_SKIPLEN: skip_d = n_sat;
						default: skip_d = skip_q;
					endcase
				end
			end
			PH_PAYLOAD: begin
				res.payload_valid = 1'b1;
				res.payload_value = data_byte;
				skip_d            = skip_q - LEN_W'(1);
			end
			PH_SKIPBYTE: skip_d = skip_q - LEN_W'(1);
			default: skip_d = skip_q;
		endcase
		res.message_done   = last_byte;
		res.message_ok     = last_byte && ok;
		res.port_number    = port_d;
		res.payload_length = LEN_OUT_W'(len_d);
		if (last_byte && !ok) begin
			res.port_number    = '0;
			res.payload_length = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_KEY;
			accum_q  <= '0;
			nbytes_q <= '0;
			skip_q   <= '0;
			port_q   <= '0;
			len_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (last_byte) begin
				accum_q  <= '0;
				nbytes_q <= '0;
				skip_q   <= '0;
				port_q   <= '0;
				len_q    <= '0;
			end else begin
				accum_q  <= accum_d;
				nbytes_q <= nbytes_d;
				skip_q   <= skip_d;
				port_q   <= port_d;
				len_q    <= len_d;
			end
		end
	end

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_byte |=> phase_q == PH_KEY && nbytes_q == '0 && port_q == '0)
		else $error("state not cleared after message end");

	a_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD || phase_q == PH_SKIPBYTE) |-> skip_q != '0)
		else $error("byte phase entered with zero count");

	a_nbytes_phase: assert property (@(posedge clk) disable iff (!arst_n)
		nbytes_q != '0 |-> (phase_q == PH_KEY || phase_q == PH_PORT ||
			phase_q == PH_PLEN || phase_q == PH_SKIPVAR || phase_q == PH_SKIPLEN))
		else $error("varint byte count left over outside a varint phase");

	a_valid_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.payload_valid && res.payload_clear))
		else $error("payload byte and payload clear on the same word");

endmodule

// ----- rtl/protobuf_data_field_parser.sv -----
// Top level of the protobuf data field parser: input register, parse core, result register.
// Depends on pdf_pkg and pdf_parser (which uses pdf_varint).
//
// Streams a decoded message in one byte per word (tlast on the final byte) and decodes
// protobuf wire format for a message with field 1 (varint, port number, low 32 bits kept)
// and field 2 (length-delimited payload). Each input word yields exactly one output word,
// in order. Payload bytes come out flagged in tuser[0]; tuser[1] marks the word that
// starts a new payload field, which replaces any earlier payload. Unknown fields of wire
// types 0, 1, 2 and 5 are skipped; wire types 3, 4, 6, 7, a varint over ten bytes, or a
// field cut off by tlast make the message fail, after which the rest of the message is
// ignored. Lengths saturate at MAX_MESSAGE_BYTES. On the tlast word the output carries
// message_ok, the port number and the last payload length (both zero on failure), and
// all parse state returns to its reset values for the next message.
// Throughput is one byte per clock with no gaps while m_axis_tready stays high: every byte
// is decoded by combinational compare and shift logic against the parse state registers.
// Each byte passes through the input register and then the result register; backpressure
// from the output propagates combinationally to s_axis_tready.
module protobuf_data_field_parser import pdf_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [7:0] payload_value, [8] message_ok,
	                                    // [40:9] port_number, [49:41] payload_length, zero pad
	output logic [1:0]  m_axis_tuser,   // [0] payload_valid, [1] payload_clear
	output logic        m_axis_tlast    // message_done
);

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// result register
	logic              valid_s2;
	pdf_result_t       res_s2;

	pdf_result_t       res;
	logic              advance;

	// a word moves into the result register whenever that slot is free or draining
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	pdf_parser #(
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {6'd0, res_s2.payload_length, res_s2.port_number,
		res_s2.message_ok, res_s2.payload_value};
	assign m_axis_tuser  = {res_s2.payload_clear, res_s2.payload_valid};
	assign m_axis_tlast  = res_s2.message_done;

endmodule

// ----- bench/pdf_stream_checker.sv -----
`timescale 1ns / 1ps
// Watches both stream channels of the protobuf data field parser, predicts each output word
// from the accepted input words and compares field by field. Depends on pdf_pkg only.
module pdf_stream_checker import pdf_pkg::*; #(
	parameter int MAX_MESSAGE_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [55:0] m_axis_tdata,   // [7:0] payload_value, [8] message_ok,
	                                    // [40:9] port_number, [49:41] payload_length
	input  logic [1:0]  m_axis_tuser,   // [0] payload_valid, [1] payload_clear
	input  logic        m_axis_tlast,   // message_done
	output int          fail_count,
	output int          outstanding,
	output int          messages_ended,
	output int          messages_ok,
	output int          payload_words,
	output int          payload_starts
);

	localparam int PRINT_CAP = 40;

	// predictor state
	pdf_phase_t           phase;
	logic [ACC_W-1:0]     acc;
	logic [NB_W-1:0]      nbytes;
	int                   skip_left;
	bit                   halted;
	logic [PORT_W-1:0]    port_q;
	logic [LEN_OUT_W-1:0] len_q;

	pdf_result_t pending_results[$];
	int mismatches = 0;
	int results_seen = 0;
	int n_ended = 0;
	int n_ok = 0;
	int n_payload = 0;
	int n_starts = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < PRINT_CAP) begin
			$display("%0t: output word %0d: %s got 0x%0h, expected 0x%0h",
				$time, results_seen, what, got, want);
		end
		mismatches++;
	endtask

	task automatic restart_parse();
		phase     = PH_KEY;
		acc       = '0;
		nbytes    = '0;
		skip_left = 0;
		halted    = 1'b0;
		port_q    = '0;
		len_q     = '0;
	endtask

	task automatic abort_parse();
		halted    = 1'b1;
		phase     = PH_HALT;
		acc       = '0;
		nbytes    = '0;
		skip_left = 0;
	endtask

	// one varint byte; sat makes value bits past the accumulator saturate it
	task automatic take_varint(input logic [7:0] b, input bit sat, output bit done);
		logic [63:0] bits7;
		bits7 = {57'd0, b[6:0]};
		done  = 1'b0;
		if (nbytes < VARINT_SLOTS)
			acc = acc | ACC_W'(bits7 << (7 * nbytes));
		else if (bits7 != 0 && sat)
			acc = '1;
		if (!b[CONT_BIT]) begin
			nbytes = '0;
			done   = 1'b1;
		end else if (nbytes >= VARINT_LAST_IDX) begin
			abort_parse();
		end else begin
			nbytes++;
		end
	endtask

	function automatic int clamp_len(input logic [ACC_W-1:0] v);
		return (v > ACC_W'(MAX_MESSAGE_BYTES)) ? MAX_MESSAGE_BYTES : int'(v);
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic eom, output pdf_result_t r);
		bit                done;
		logic [PORT_W-1:0] fnum;
		logic [2:0]        wt;
		int                n;
		r = '0;
		case (phase)
			PH_KEY: begin
				take_varint(b, 1'b0, done);
				if (done) begin
					fnum = acc[ACC_W-1:3];
					wt   = acc[2:0];
					acc  = '0;
					if (fnum == FIELD_PORT && wt == WT_VARINT) begin
						phase = PH_PORT;
					end else if (fnum == FIELD_PAYLOAD && wt == WT_LEN) begin
						phase = PH_PLEN;
					end else begin
						case (wt)
							WT_VARINT: phase = PH_SKIPVAR;
							WT_I64: begin
								skip_left = SKIP_I64;
								phase     = PH_SKIPBYTE;
							end
							WT_LEN: phase = PH_SKIPLEN;
							WT_I32: begin
								skip_left = SKIP_I32;
								phase     = PH_SKIPBYTE;
							end
							default: abort_parse();
						endcase
					end
				end
			end
			PH_PORT: begin
				take_varint(b, 1'b0, done);
				if (done) begin
					port_q = acc[PORT_W-1:0];
					acc    = '0;
					phase  = PH_KEY;
				end
			end
			PH_PLEN: begin
				take_varint(b, 1'b1, done);
				if (done) begin
					n               = clamp_len(acc);
					acc             = '0;
					len_q           = LEN_OUT_W'(n);
					r.payload_clear = 1'b1;
					skip_left       = n;
					if (n == 0)
						phase = PH_KEY;
					else
						phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				r.payload_valid = 1'b1;
				r.payload_value = b;
				skip_left--;
				if (skip_left == 0)
					phase = PH_KEY;
			end
			PH_SKIPVAR: begin
				take_varint(b, 1'b0, done);
				if (done) begin
					acc   = '0;
					phase = PH_KEY;
				end
			end
			PH_SKIPLEN: begin
				take_varint(b, 1'b1, done);
				if (done) begin
					n         = clamp_len(acc);
					acc       = '0;
					skip_left = n;
					if (n == 0)
						phase = PH_KEY;
					else
						phase = PH_SKIPBYTE;
				end
			end
			PH_SKIPBYTE: begin
				skip_left--;
				if (skip_left == 0)
					phase = PH_KEY;
			end
			default: ;  // halted: rest of message ignored
		endcase

		r.port_number    = port_q;
		r.payload_length = len_q;
		if (eom) begin
			r.message_done = 1'b1;
			r.message_ok   = !halted && phase == PH_KEY && nbytes == 0;
			if (!r.message_ok) begin
				r.port_number    = '0;
				r.payload_length = '0;
			end
			restart_parse();
		end
	endtask

	always @(posedge clk) begin : monitor
		pdf_result_t want;
		pdf_result_t got;
		if (!arst_n) begin
			restart_parse();
			pending_results.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(s_axis_tdata, s_axis_tlast, want);
				pending_results.push_back(want);
				n_payload += want.payload_valid;
				n_starts  += want.payload_clear;
				n_ended   += want.message_done;
				n_ok      += want.message_ok;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.payload_valid  = m_axis_tuser[0];
				got.payload_value  = m_axis_tdata[7:0];
				got.payload_clear  = m_axis_tuser[1];
				got.message_done   = m_axis_tlast;
				got.message_ok     = m_axis_tdata[8];
				got.port_number    = m_axis_tdata[40:9];
				got.payload_length = m_axis_tdata[49:41];
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected word, tdata", 64'(m_axis_tdata), '0);
				end else begin
					want = pending_results.pop_front();
					if (got.payload_valid != want.payload_valid)
						report_mismatch("payload_valid", got.payload_valid, want.payload_valid);
					if (got.payload_value != want.payload_value)
						report_mismatch("payload_value", got.payload_value, want.payload_value);
					if (got.payload_clear != want.payload_clear)
						report_mismatch("payload_clear", got.payload_clear, want.payload_clear);
					if (got.message_done != want.message_done)
						report_mismatch("message_done", got.message_done, want.message_done);
					if (got.message_ok != want.message_ok)
						report_mismatch("message_ok", got.message_ok, want.message_ok);
					if (got.port_number != want.port_number)
						report_mismatch("port_number", got.port_number, want.port_number);
					if (got.payload_length != want.payload_length)
						report_mismatch("payload_length", got.payload_length,
							want.payload_length);
				end
				results_seen++;
			end
		end
		fail_count     <= mismatches;
		outstanding    <= pending_results.size();
		messages_ended <= n_ended;
		messages_ok    <= n_ok;
		payload_words  <= n_payload;
		payload_starts <= n_starts;
	end

endmodule

// ----- bench/protobuf_data_field_parser_tb.sv -----
`timescale 1ns / 1ps
// Top of the protobuf data field parser bench: clock, reset, message stimulus and verdict.
// Depends on pdf_pkg, the parser RTL and pdf_stream_checker.
module protobuf_data_field_parser_tb;

	import pdf_pkg::*;

	localparam int MAX_MSG      = 256;
	localparam int RESET_CYCLES = 12;
	localparam int TOTAL_WORDS  = 1550;
	localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES = 8;     // drain time past the input and result registers, plus margin

	// wire types the parser must reject
	localparam logic [2:0] WT_START_GROUP = 3'd3;
	localparam logic [2:0] WT_END_GROUP   = 3'd4;
	localparam logic [2:0] WT_RSVD6       = 3'd6;
	localparam logic [2:0] WT_RSVD7       = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
	logic        s_axis_tlast = 1'b0; // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;        // [7:0] payload_value, [8] message_ok,
	                                  // [40:9] port_number, [49:41] payload_length
	logic [1:0]  m_axis_tuser;        // [0] payload_valid, [1] payload_clear
	logic        m_axis_tlast;        // message_done

	int fail_count;
	int outstanding;
	int messages_ended;
	int messages_ok;
	int payload_words;
	int payload_starts;

	int send_idle_pct = 19;  // chance per cycle that the sender holds off
	int recv_idle_pct = 85;  // chance per cycle that the receiver stalls
	int words_sent = 0;
	int quiet_cycles = 0;

	logic [7:0] frame_bytes[$];  // message under construction

	always #4 clk = ~clk;

	protobuf_data_field_parser #(
		.MAX_MESSAGE_BYTES(MAX_MSG)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	pdf_stream_checker #(
		.MAX_MESSAGE_BYTES(MAX_MSG)
	) checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.outstanding   (outstanding),
		.messages_ended(messages_ended),
		.messages_ok   (messages_ok),
		.payload_words (payload_words),
		.payload_starts(payload_starts)
	);

	// receiver backpressure, redrawn every cycle
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog: a lost word or a hung handshake ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("no word moved for %0d cycles, %0d results outstanding",
				STALL_LIMIT, outstanding);
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---- message building ----

	// varint with at least min_bytes bytes (padded with continuation groups)
	task automatic add_varint(input logic [63:0] v, input int min_bytes);
		logic [63:0] rest;
		logic [7:0]  b;
		int          n;
		rest = v;
		n    = 0;
		do begin
			b    = {1'b0, rest[6:0]};
			rest = rest >> 7;
			n++;
			if (rest != 0 || n < min_bytes)
				b[7] = 1'b1;
			frame_bytes.push_back(b);
		end while (rest != 0 || n < min_bytes);
	endtask

	task automatic add_key(input logic [63:0] field, input logic [2:0] wt, input int min_bytes);
		add_varint((field << 3) | 64'(wt), min_bytes);
	endtask

	task automatic add_random_bytes(input int count);
		repeat (count) frame_bytes.push_back(8'($urandom));
	endtask

	// mostly short; now and then near the cap, or past it so the length saturates
	function automatic logic [63:0] pick_length(input int typical_max);
		int k;
		k = $urandom_range(99);
		if (k == 0)
			return 64'($urandom_range(MAX_MSG, MAX_MSG - 56));
		if (k == 1)
			return $urandom_range(1) ? 64'($urandom_range(5000, MAX_MSG + 1))
				: {$urandom, $urandom};
		return 64'($urandom_range(typical_max, 0));
	endfunction

	function automatic int body_bytes(input logic [63:0] len);
		return (len > MAX_MSG) ? MAX_MSG : int'(len);
	endfunction

	task automatic add_port_field();
		logic [63:0] value;
		logic [63:0] wide;
		int          k;
		k = $urandom_range(99);
		if (k < 10) begin
			// junk above key bit 34 is dropped, so this still reads as the port field
			wide = {$urandom, $urandom} & ~64'h7_FFFF_FFFF;
			add_varint(wide | (64'(FIELD_PORT) << 3) | 64'(WT_VARINT), 1);
		end else begin
			add_key(FIELD_PORT, WT_VARINT, (k < 20) ? $urandom_range(10, 1) : 1);
		end
		k = $urandom_range(99);
		if (k < 10)
			value = '0;
		else if (k < 20)
			value = 64'hFFFF_FFFF;
		else if (k < 55)
			value = 64'($urandom);
		else if (k < 75)
			value = 64'($urandom_range(300, 0));
		else
			value = {$urandom, $urandom};  // upper half truncated by the parser
		add_varint(value, ($urandom_range(99) < 25) ? $urandom_range(10, 1) : 1);
	endtask

	task automatic add_payload_field();
		logic [63:0] len;
		len = pick_length(12);
		add_key(FIELD_PAYLOAD, WT_LEN, ($urandom_range(99) < 10) ? $urandom_range(4, 2) : 1);
		add_varint(len, ($urandom_range(99) < 15) ? $urandom_range(10, 1) : 1);
		add_random_bytes(body_bytes(len));
	endtask

	task automatic add_skipped_field();
		logic [63:0] field;
		logic [63:0] len;
		logic [2:0]  wt;
		int          k;
		case ($urandom_range(3))
			0: wt = WT_VARINT;
			1: wt = WT_I64;
			2: wt = WT_LEN;
			default: wt = WT_I32;
		endcase
		k = $urandom_range(99);
		if (k < 15)
			field = FIELD_PORT;     // wrong wire type for the port
		else if (k < 30)
			field = FIELD_PAYLOAD;  // wrong wire type for the payload
		else if (k < 80)
			field = 64'($urandom_range(40, 0));
		else
			field = {$urandom, $urandom};
		add_key(field, wt, 1);
		case (wt)
			WT_VARINT: add_varint({$urandom, $urandom} >> $urandom_range(63, 0), 1);
			WT_I64:    add_random_bytes(SKIP_I64);
			WT_I32:    add_random_bytes(SKIP_I32);
			default: begin
				len = pick_length(12);
				add_varint(len, 1);
				add_random_bytes(body_bytes(len));
			end
		endcase
	endtask

	task automatic add_bad_wire_type();
		logic [2:0] wt;
		case ($urandom_range(3))
			0: wt = WT_START_GROUP;
			1: wt = WT_END_GROUP;
			2: wt = WT_RSVD6;
			default: wt = WT_RSVD7;
		endcase
		add_key(64'($urandom_range(40, 0)), wt, 1);
		add_random_bytes($urandom_range(6, 0));  // must be ignored
	endtask

	// ten bytes all carrying the continuation bit: the tenth one fails the message
	task automatic add_runaway_varint();
		case ($urandom_range(3))
			0: ;  // in the key itself
			1: add_key(FIELD_PORT, WT_VARINT, 1);
			2: add_key(FIELD_PAYLOAD, WT_LEN, 1);
			default: add_key(64'($urandom_range(40, 3)), $urandom_range(1) ? WT_LEN : WT_VARINT, 1);
		endcase
		repeat (10) frame_bytes.push_back(8'h80 | 8'($urandom_range(127)));
		add_random_bytes($urandom_range(4, 0));
	endtask

	// mostly well-formed messages; the rest end in an error, get cut short, or are noise
	task automatic build_message();
		int k;
		frame_bytes.delete();
		repeat ($urandom_range(5, 1)) begin
			k = $urandom_range(99);
			if (k < 35)
				add_port_field();
			else if (k < 70)
				add_payload_field();
			else
				add_skipped_field();
		end
		k = $urandom_range(99);
		if (k < 70) begin
			// clean end
		end else if (k < 77) begin
			add_bad_wire_type();
		end else if (k < 84) begin
			add_runaway_varint();
		end else if (k < 94) begin
			if (frame_bytes.size() > 1)
				repeat ($urandom_range(frame_bytes.size() - 1, 1)) void'(frame_bytes.pop_back());
		end else begin
			frame_bytes.delete();
			add_random_bytes($urandom_range(12, 1));
		end
	endtask

	// ---- driving ----

	task automatic send_word(input logic [7:0] b, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eom;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++)
			send_word(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// port 150 as a two-byte varint
		frame_bytes.delete();
		add_key(FIELD_PORT, WT_VARINT, 1);
		add_varint(150, 1);
		send_frame();

		// two payload bytes at the byte extremes
		frame_bytes.delete();
		add_key(FIELD_PAYLOAD, WT_LEN, 1);
		add_varint(2, 1);
		frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(8'h00);
		send_frame();

		// start-group wire type; the payload field after it must be ignored
		frame_bytes.delete();
		add_key(FIELD_PORT, WT_START_GROUP, 1);
		add_key(FIELD_PAYLOAD, WT_LEN, 1);
		add_varint(1, 1);
		frame_bytes.push_back(8'hAA);
		send_frame();

		// payload of five cut off after one byte
		frame_bytes.delete();
		add_key(FIELD_PAYLOAD, WT_LEN, 1);
		add_varint(5, 1);
		frame_bytes.push_back(8'h01);
		send_frame();

		// port varint still continuing at its tenth byte
		frame_bytes.delete();
		add_key(FIELD_PORT, WT_VARINT, 1);
		repeat (10) frame_bytes.push_back(8'h80);
		send_frame();

		// random messages across three idle mixes
		while (words_sent < TOTAL_WORDS) begin
			if (words_sent >= 2 * TOTAL_WORDS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end else if (words_sent >= TOTAL_WORDS / 3) begin
				send_idle_pct = 85;
				recv_idle_pct <= 19;
			end
			build_message();
			send_frame();
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);

		// the watchdog covers a result that never shows up
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Drove %0d words in %0d messages: %0d parsed ok, %0d rejected or cut off.",
			words_sent, messages_ended, messages_ok, messages_ended - messages_ok);
		$display("Saw %0d payload bytes and %0d payload starts under three idle mixes.",
			payload_words, payload_starts);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/pdf_pkg.sv
rtl/pdf_varint.sv
rtl/pdf_parser.sv
rtl/protobuf_data_field_parser.sv
bench/pdf_stream_checker.sv
bench/protobuf_data_field_parser_tb.sv
